// ===== rtl/dssp_pkg.sv =====
// Shared constants, types and control structs for the dual stack block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dssp_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int STORE_DEPTH = 2 * STACK_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    localparam logic [DATA_W-1:0] EMPTY_POP_VALUE = 32'h7FFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_SORTED = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // where the popped value of a result comes from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_EMPTY,
        SRC_RDATA
    } t_res_src;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_POP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic     load_item;
        logic     dec_slot;
        logic     wr_val;
        logic     wr_shift;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     cnt_clr;
        logic     res_set;
        t_status  res_code;
        t_res_src res_src;
        logic     load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic slot_zero;
        logic greater;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/dssp_if.sv =====
// Valid/ready channel interfaces for the command and result beats.
// Depends on dssp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dssp_in_if
    import dssp_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic                     stack_select;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output stack_select, output value,
                    input ready);
    modport sink   (input valid, input operation, input stack_select, input value,
                    output ready);
endinterface

interface dssp_out_if
    import dssp_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/dssp_datapath.sv =====
// Datapath: shared word store, fill counts, slot pointer and result registers.
// Depends on dssp_pkg; driven by dssp_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module dssp_datapath
    import dssp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic                     i_stack_select,
    input  wire logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                      o_stat,
    output logic signed [DATA_W-1:0]      o_popped_value,
    output logic [STATUS_W-1:0]           o_status
);

    t_op                      r_op;
    logic                     r_sel;
    logic signed [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]         r_slot;
    logic [CNT_W-1:0]         r_count [2];
    logic [DATA_W-1:0]        r_mem [STORE_DEPTH];
    logic [DATA_W-1:0]        r_rdata;
    logic [DATA_W-1:0]        r_res_value;
    t_status                  r_res_status;
    logic [DATA_W-1:0]        r_out_value;
    t_status                  r_out_status;

    logic [ADDR_W-1:0] w_base;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_wr_en;
    logic [DATA_W-1:0] w_res_value;

    assign w_base    = r_sel ? ADDR_W'(STACK_DEPTH) : '0;
    assign w_wr_addr = w_base + ADDR_W'(r_slot);
    // read one below the slot; look two below when the slot moves down this cycle
    assign w_rd_addr = w_base + ADDR_W'(r_slot)
                     - (i_cmd.dec_slot ? ADDR_W'(2) : ADDR_W'(1));
    assign w_wr_en   = i_cmd.wr_val | i_cmd.wr_shift;
    assign w_wr_data = i_cmd.wr_shift ? r_rdata : r_val;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count[0] <= '0;
            r_count[1] <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count[r_sel] <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count[r_sel] <= r_count[r_sel] + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count[r_sel] <= r_count[r_sel] - CNT_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.res_src)
            SRC_EMPTY: w_res_value = EMPTY_POP_VALUE;
            SRC_RDATA: w_res_value = r_rdata;
            default:   w_res_value = '0;
        endcase
    end

    // item, slot pointer and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= t_op'(i_operation);
            r_sel  <= i_stack_select;
            r_val  <= i_value;
            r_slot <= r_count[i_stack_select];
        end else if (i_cmd.dec_slot) begin
            r_slot <= r_slot - CNT_W'(1);
        end
        if (i_cmd.res_set) begin
            r_res_value  <= w_res_value;
            r_res_status <= i_cmd.res_code;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.full      = (r_slot == CNT_W'(STACK_DEPTH));
    assign o_stat.empty     = (r_slot == '0);
    assign o_stat.slot_zero = (r_slot == '0);
    assign o_stat.greater   = ($signed(r_rdata) > r_val);

    assign o_popped_value = $signed(r_out_value);
    assign o_status       = STATUS_W'(r_out_status);

endmodule

`default_nettype wire

// ===== rtl/dssp_ctrl.sv =====
// Controller: sequences one command beat through decode, shift and pop steps.
// Depends on dssp_pkg; commands dssp_datapath through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module dssp_ctrl
    import dssp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_PUSH:   n_state = S_DONE;
                    OP_SORTED: begin
                        if (i_stat.full || i_stat.slot_zero) n_state = S_DONE;
                        else                                 n_state = S_SHIFT;
                    end
                    OP_POP: begin
                        if (i_stat.empty) n_state = S_DONE;
                        else              n_state = S_POP;
                    end
                    default:   n_state = S_DONE;
                endcase
            end
            S_SHIFT: begin
                if (i_stat.slot_zero || !i_stat.greater) n_state = S_DONE;
            end
            S_POP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = ST_DONE;
        o_cmd.res_src  = SRC_ZERO;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_PUSH, OP_SORTED: begin
                        o_cmd.res_set = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_code = ST_FULL;
                        end else if (i_stat.op == OP_PUSH || i_stat.slot_zero) begin
                            o_cmd.wr_val  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end else begin
                            o_cmd.res_set = 1'b0;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_code = ST_EMPTY;
                            o_cmd.res_src  = SRC_EMPTY;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.res_set = 1'b1;
                    end
                endcase
            end
            S_SHIFT: begin
                if (i_stat.slot_zero || !i_stat.greater) begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_set = 1'b1;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.dec_slot = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_src = SRC_RDATA;
            end
            S_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.load_out)
        else $error("result register overwritten while held");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_shift |-> !i_stat.slot_zero)
        else $error("shift below stack base");

    a_count_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cnt_inc, o_cmd.cnt_dec, o_cmd.cnt_clr}))
        else $error("conflicting fill count updates");
`endif

endmodule

`default_nettype wire

// ===== rtl/dual_stack_with_sorted_push_unit.sv =====
// Sequencing: push, clear, full push, empty pop and sorted push onto an empty stack go
// from decode straight to done; pop passes through the pop step; any other sorted push
// runs the shift step and moves k entries up, k <= STACK_DEPTH - 1.
// Flow: one command at a time; a new beat is taken only after the previous result has
// left the done state; the sorted-push shift loop sets the worst case.
// Reset: synchronous active-low i_rst_n empties both stacks; store words keep old data.
`timescale 1ns / 1ps
`default_nettype none

// Two stacks share one store of 2*STACK_DEPTH words: stack A sits in the lower
// half, stack B in the upper half.  Each command beat carries an operation, a
// stack select and a value; each produces exactly one result beat.
//
// Structure:
//   dssp_ctrl     - state machine, idle / decode / shift / pop / done, and the
//                   result valid flag.
//   dssp_datapath - store (one write and one registered read per cycle), the
//                   two fill counts, the slot pointer and result registers.
//
// Sorted push walks down from the top: each shift cycle compares the word
// just read with the new value; while it is greater the word moves up one
// slot and the read address looks one further down, so one entry moves per
// cycle.  The value is written into the freed slot when the compare fails or
// the base is reached, so equal words stay below it.
//
// A finished result waits in the result register; the controller holds in its
// done state until the output register is free, so a new beat is taken as soon as
// the previous result has been handed on to the output register.
module dual_stack_with_sorted_push_unit
    import dssp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dssp_in_if.sink    i_cmd,
    dssp_out_if.source o_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    dssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dssp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operation    (i_cmd.operation),
        .i_stack_select (i_cmd.stack_select),
        .i_value        (i_cmd.value),
        .o_stat         (w_stat),
        .o_popped_value (o_res.popped_value),
        .o_status       (o_res.status)
    );

endmodule

`default_nettype wire

// ===== dv/dual_stack_with_sorted_push_unit_tb.sv =====
// Self-checking testbench for the dual stack unit with sorted push.
// Needs dssp_pkg, dssp_if.sv and the unit RTL; a shadow class predicts every result beat.
`timescale 1ns / 1ps

module dual_stack_with_sorted_push_unit_tb;
    import dssp_pkg::*;

    // The limit leaves ample slack over the slowest honest run: about 1950 beats,
    // some of them held by long sink stalls.
    localparam int unsigned CYCLE_LIMIT     = 400_000;
    localparam int unsigned ITEMS_PER_PHASE = 630;
    localparam int unsigned SETTLE_CYCLES   = 2 * STACK_DEPTH + 8;
    localparam int unsigned MAX_PRINTED     = 50;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        t_status                  status;
    } t_stack_result;

    // Shadow copy of both stacks plus the queue of result beats still awaited.
    class stack_shadow;
        logic signed [DATA_W-1:0] words [STORE_DEPTH];
        int unsigned              fill [2];
        t_stack_result            pending_results [$];
        int unsigned              mismatches;
        int unsigned              results_seen;
        int unsigned              op_count [4];
        int unsigned              full_count;
        int unsigned              empty_count;
        int unsigned              deepest_shift;

        function t_stack_result apply_stack_op(t_op op, logic sel,
                                               logic signed [DATA_W-1:0] val);
            t_stack_result r;
            int unsigned   base;
            int unsigned   n;
            int unsigned   slot;
            base           = sel ? STACK_DEPTH : 0;
            n              = fill[sel];
            r.popped_value = '0;
            r.status       = ST_DONE;
            case (op)
                OP_PUSH, OP_SORTED: begin
                    if (n >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                        full_count++;
                    end else begin
                        slot = n;
                        // larger words move up one slot; equal words stay beneath
                        if (op == OP_SORTED) begin
                            while (slot > 0 && words[base + slot - 1] > val) begin
                                words[base + slot] = words[base + slot - 1];
                                slot--;
                            end
                            if (n - slot > deepest_shift) begin
                                deepest_shift = n - slot;
                            end
                        end
                        words[base + slot] = val;
                        fill[sel]          = n + 1;
                    end
                end
                OP_POP: begin
                    if (n == 0) begin
                        r.popped_value = EMPTY_POP_VALUE;
                        r.status       = ST_EMPTY;
                        empty_count++;
                    end else begin
                        fill[sel]      = n - 1;
                        r.popped_value = words[base + n - 1];
                    end
                end
                default: begin
                    fill[sel] = 0;
                end
            endcase
            return r;
        endfunction

        function void note_command(t_op op, logic sel, logic signed [DATA_W-1:0] val);
            op_count[op]++;
            pending_results.push_back(apply_stack_op(op, sel, val));
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) begin
                $display("MISMATCH at %0t ns: %s", $time, what);
            end
            mismatches++;
        endtask

        task check_result(logic signed [DATA_W-1:0] popped, logic [STATUS_W-1:0] status);
            t_stack_result awaited;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, value %0d status %0d",
                                          popped, status));
            end else begin
                awaited = pending_results.pop_front();
                if (status !== awaited.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              status, awaited.status));
                end
                if (popped !== awaited.popped_value) begin
                    report_mismatch($sformatf("popped value %0d, predicted %0d",
                                              popped, awaited.popped_value));
                end
            end
        endtask
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 7;
    int unsigned snk_idle_pct = 71;
    stack_shadow book;

    dssp_in_if  cmd_if ();
    dssp_out_if res_if ();

    dual_stack_with_sorted_push_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Every channel input known from time zero.
    initial begin
        book                = new();
        cmd_if.valid        = 1'b0;
        cmd_if.operation    = OP_PUSH;
        cmd_if.stack_select = 1'b0;
        cmd_if.value        = '0;
        res_if.ready        = 1'b0;
    end

    // Result side: a beat moves when valid and ready are both high at the edge.
    // Ready is redrawn every cycle, so stalls land on every state of the unit.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            book.check_result(res_if.popped_value, res_if.status);
        end
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Random value with a strong lean towards the extremes and small numbers,
    // so equal words meet often in sorted pushes.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(6) - 3;
            default: return $urandom();
        endcase
    endfunction

    // One command beat. While the sender idles the payload carries junk.
    task automatic send_command(t_op op, logic sel, logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid        <= 1'b0;
            cmd_if.operation    <= t_op'($urandom_range(3));
            cmd_if.stack_select <= 1'($urandom_range(1));
            cmd_if.value        <= $urandom();
            @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= op;
        cmd_if.stack_select <= sel;
        cmd_if.value        <= val;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        book.note_command(op, sel, val);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (book.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Directed opening: empty pops, clears, extreme words, a full stack B built
    // by sorted pushes (equal words included), pushes to full, clear and drain.
    // Values on pop and clear are junk on purpose.
    task automatic run_directed();
        send_command(OP_POP,    1'b0, 32'h1234_5678);
        send_command(OP_POP,    1'b1, -1);
        send_command(OP_CLEAR,  1'b0, 32'hFFFF_FFFF);
        send_command(OP_PUSH,   1'b0, 32'h7FFF_FFFF);
        send_command(OP_PUSH,   1'b0, 32'h8000_0000);
        send_command(OP_SORTED, 1'b1, 0);
        send_command(OP_SORTED, 1'b1, -1);
        send_command(OP_SORTED, 1'b1, 32'h7FFF_FFFF);
        send_command(OP_SORTED, 1'b1, 32'h8000_0000);
        send_command(OP_SORTED, 1'b1, -1);
        send_command(OP_SORTED, 1'b1, 32'h5555_5555);
        send_command(OP_SORTED, 1'b1, 32'hAAAA_AAAA);
        send_command(OP_SORTED, 1'b1, 32'h8000_0000);
        send_command(OP_SORTED, 1'b1, 3);
        send_command(OP_PUSH,   1'b1, 3);
        send_command(OP_POP,    1'b1, 32'h0F0F_0F0F);
        send_command(OP_CLEAR,  1'b1, 32'hF0F0_F0F0);
        send_command(OP_POP,    1'b1, 0);
        send_command(OP_POP,    1'b0, 7);
        send_command(OP_POP,    1'b0, 32'h8000_0000);
        send_command(OP_POP,    1'b0, 32'h7FFF_FFFF);
    endtask

    // Random part, built from bursts on one stack: descending sorted fills
    // (every new word sinks far down), mixed fills, drains, free mixes, and
    // a noise burst that clears first and hops between the stacks.
    task automatic run_random_phase(int unsigned n_items);
        int unsigned              sent;
        int unsigned              mode;
        int unsigned              len;
        int unsigned              r;
        logic                     sel;
        logic signed [DATA_W-1:0] walk;
        logic signed [DATA_W-1:0] val;
        t_op                      op;
        sent = 0;
        while (sent < n_items) begin
            sel  = 1'($urandom_range(1));
            mode = $urandom_range(9);
            len  = $urandom_range(3, 14);
            walk = pick_value();
            for (int i = 0; i < len; i++) begin
                r   = $urandom_range(99);
                val = pick_value();
                case (mode)
                    0, 1, 2: begin
                        walk = walk - $urandom_range(2);
                        val  = walk;
                        op   = (r < 80) ? OP_SORTED : (r < 90) ? OP_PUSH : OP_POP;
                    end
                    3, 4: begin
                        op = (r < 50) ? OP_SORTED : (r < 85) ? OP_PUSH : OP_POP;
                    end
                    5, 6: begin
                        op = (r < 80) ? OP_POP : OP_SORTED;
                    end
                    7, 8: begin
                        op = (r < 6) ? OP_CLEAR : t_op'($urandom_range(2));
                    end
                    default: begin
                        op  = (i == 0) ? OP_CLEAR : t_op'($urandom_range(3));
                        sel = 1'($urandom_range(1));
                    end
                endcase
                send_command(op, sel, val);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // sender mostly busy, sink stalls hard
        run_random_phase(ITEMS_PER_PHASE);
        wait_drained();

        // sender gappy, sink nearly always ready
        src_idle_pct = 71;
        snk_idle_pct = 7;
        run_random_phase(ITEMS_PER_PHASE);
        wait_drained();

        // back to back, no idling either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_phase(ITEMS_PER_PHASE);
        wait_drained();

        // let any stray beat show up before judging
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d push, %0d sorted push, %0d pop and %0d clear beats; %0d results checked",
                 book.op_count[OP_PUSH], book.op_count[OP_SORTED],
                 book.op_count[OP_POP], book.op_count[OP_CLEAR], book.results_seen);
        $display("Pushes to a full stack %0d, empty pops %0d, deepest sorted shift %0d, errors %0d",
                 book.full_count, book.empty_count, book.deepest_shift, book.mismatches);
        if (book.mismatches == 0 && book.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, book.pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
